// ===== hw/rtl/mbrd_pkg.sv =====
// Package: types, constants and the control program of the MPE bend range declarer.
package mbrd_pkg;

  localparam logic [3:0] MaxMembers   = 4'd15;
  localparam logic [6:0] CcSelectHigh = 7'd101;
  localparam logic [6:0] CcSelectLow  = 7'd100;
  localparam logic [6:0] CcDataEntry  = 7'd6;
  localparam logic [6:0] RangeLimit   = 7'd96;
  localparam logic [6:0] RpnLowMpe    = 7'd6;
  localparam logic [3:0] KindControl  = 4'hB;
  localparam logic [3:0] KindNoteOn   = 4'h9;

  typedef enum logic [1:0] {
    CfgZoneIsLower  = 2'd0,
    CfgMemberCount  = 2'd1,
    CfgBendRange    = 2'd2,
    CfgUnused       = 2'd3
  } cfg_index_e;

  typedef logic [2:0] upc_t;

  localparam upc_t UpcDispatch   = 3'd0;
  localparam upc_t UpcConfigFwd  = 3'd1;
  localparam upc_t UpcSelHigh    = 3'd2;
  localparam upc_t UpcSelLow     = 3'd3;
  localparam upc_t UpcDataEntry  = 3'd4;
  localparam upc_t UpcNoteStart  = 3'd5;
  localparam upc_t UpcForward    = 3'd6;
  localparam upc_t UpcSpare      = 3'd7;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_FWD,
    EMIT_SEL_HIGH,
    EMIT_SEL_LOW
  } emit_e;

  typedef enum logic [1:0] {
    LAST_NO,
    LAST_ALWAYS,
    LAST_EMPTY,
    LAST_END_CFG
  } last_e;

  typedef enum logic [2:0] {
    JMP_DISPATCH,
    JMP_ALWAYS,
    JMP_EMPTY,
    JMP_LOOP,
    JMP_NEXT
  } jump_e;

  typedef struct packed {
    emit_e  emit;
    logic   emit_data;
    last_e  last;
    jump_e  jump;
    upc_t   target;
    logic   inc_idx;
  } ucode_t;

  function automatic ucode_t ucode_rom(upc_t addr);
    ucode_t cw;
    cw = '{emit: EMIT_NONE, emit_data: 1'b0, last: LAST_NO, jump: JMP_ALWAYS,
           target: UpcDispatch, inc_idx: 1'b0};
    case (addr)
      UpcDispatch: begin
        cw.jump = JMP_DISPATCH;
      end
      UpcConfigFwd: begin
        cw.emit   = EMIT_FWD;
        cw.last   = LAST_EMPTY;
        cw.jump   = JMP_EMPTY;
        cw.target = UpcDispatch;
      end
      UpcSelHigh: begin
        cw.emit = EMIT_SEL_HIGH;
        cw.jump = JMP_NEXT;
      end
      UpcSelLow: begin
        cw.emit = EMIT_SEL_LOW;
        cw.jump = JMP_NEXT;
      end
      UpcDataEntry: begin
        cw.emit_data = 1'b1;
        cw.last      = LAST_END_CFG;
        cw.jump      = JMP_LOOP;
        cw.target    = UpcSelHigh;
        cw.inc_idx   = 1'b1;
      end
      UpcNoteStart: begin
        cw.jump   = JMP_EMPTY;
        cw.target = UpcForward;
      end
      UpcForward: begin
        cw.emit   = EMIT_FWD;
        cw.last   = LAST_ALWAYS;
        cw.jump   = JMP_ALWAYS;
        cw.target = UpcDispatch;
      end
      default: begin
        cw.jump   = JMP_ALWAYS;
        cw.target = UpcDispatch;
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== hw/rtl/mbrd_in_if.sv =====
// Interface: input channel carrying one MIDI message per item.
interface mbrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] status_byte;
  logic [6:0] data_one;
  logic [6:0] data_two;

  modport source (output valid, output status_byte, output data_one, output data_two,
                  input ready);
  modport sink (input valid, input status_byte, input data_one, input data_two,
                output ready);
endinterface

// ===== hw/rtl/mbrd_out_if.sv =====
// Interface: output channel carrying one emitted MIDI message per item.
interface mbrd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_status;
  logic [6:0] out_data_one;
  logic [6:0] out_data_two;
  logic       last_of_run;

  modport source (output valid, output out_status, output out_data_one,
                  output out_data_two, output last_of_run, input ready);
  modport sink (input valid, input out_status, input out_data_one,
                input out_data_two, input last_of_run, output ready);
endinterface

// ===== hw/rtl/mbrd_cfg_if.sv =====
// Interface: configuration write channel with register index and write data.
interface mbrd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [6:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/mpe_bend_range_declarer_core.sv =====
// Top level: MPE bend range declarer driven by a microcoded sequencer.
//
// Each input item is a MIDI message. Controller messages track the RPN
// selection of each channel, and a data entry under RPN 0/6 is forwarded
// and followed by a declaration burst of CC101=0, CC100=0 and CC6=range for
// every member channel of the zone. The first note-on with nonzero velocity
// before any declaration gets the same burst ahead of it. The sequencer issues
// at most one output item per program step through a single output register,
// and an emitting step waits while that register is still full; the input is
// held while a burst runs.
module mpe_bend_range_declarer_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  mbrd_in_if.sink       in_i,
  mbrd_out_if.source    out_o,
  mbrd_cfg_if.sink      cfg_i
);
  import mbrd_pkg::*;

  upc_t       upc_q, upc_d;
  logic [3:0] idx_q, idx_d;
  logic [7:0] st_q;
  logic [6:0] d1_q;
  logic [6:0] d2_q;
  logic       is_cfg_q;
  logic       declared_q;
  logic       zone_q;
  logic [3:0] members_q;
  logic [6:0] range_q;
  logic [15:0] high_zero_q;
  logic [15:0] low_six_q;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_st_q, out_st_d;
  logic [6:0] out_d1_q, out_d1_d;
  logic [6:0] out_d2_q, out_d2_d;
  logic       out_last_q, out_last_d;

  ucode_t     cw;
  logic       emitting;
  logic       out_free;
  logic       step_go;
  logic       in_accept;
  logic [3:0] members_sat;
  logic       empty;
  logic       last_member;
  logic [3:0] chan;
  logic [6:0] range_sat;
  logic [3:0] in_chi;
  logic       in_ctrl;
  logic       in_cfg_msg;
  logic       in_first_note;
  logic       last_bit;

  assign cw          = ucode_rom(upc_q);
  assign emitting    = (cw.emit != EMIT_NONE) || cw.emit_data;
  assign out_free    = !out_valid_q || out_o.ready;
  assign step_go     = !emitting || out_free;
  assign in_i.ready  = (upc_q == UpcDispatch);
  assign in_accept   = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign members_sat = (members_q > MaxMembers) ? MaxMembers : members_q;
  assign empty       = (members_sat == 4'd0);
  assign last_member = (4'(idx_q + 4'd1) == members_sat);
  assign chan        = zone_q ? 4'(idx_q + 4'd1) : 4'(4'd14 - idx_q);
  assign range_sat   = (range_q > RangeLimit) ? RangeLimit : range_q;

  assign in_chi        = in_i.status_byte[3:0];
  assign in_ctrl       = (in_i.status_byte[7:4] == KindControl);
  assign in_cfg_msg    = in_ctrl && (in_i.data_one == CcDataEntry) &&
                         high_zero_q[in_chi] && low_six_q[in_chi];
  assign in_first_note = (in_i.status_byte[7:4] == KindNoteOn) &&
                         (in_i.data_two != 7'd0) && !declared_q;

  always_comb begin
    case (cw.last)
      LAST_ALWAYS:  last_bit = 1'b1;
      LAST_EMPTY:   last_bit = empty;
      LAST_END_CFG: last_bit = last_member && is_cfg_q;
      default:      last_bit = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    out_st_d    = out_st_q;
    out_d1_d    = out_d1_q;
    out_d2_d    = out_d2_q;
    out_last_d  = out_last_q;
    if (emitting && out_free) begin
      out_valid_d = 1'b1;
      out_last_d  = last_bit;
      out_st_d    = {KindControl, chan};
      out_d2_d    = 7'd0;
      if (cw.emit_data) begin
        out_d1_d = CcDataEntry;
        out_d2_d = range_sat;
      end else begin
        case (cw.emit)
          EMIT_FWD: begin
            out_st_d = st_q;
            out_d1_d = d1_q;
            out_d2_d = d2_q;
          end
          EMIT_SEL_HIGH: out_d1_d = CcSelectHigh;
          EMIT_SEL_LOW:  out_d1_d = CcSelectLow;
          default:       out_d1_d = d1_q;
        endcase
      end
    end
  end

  always_comb begin
    upc_d = upc_q;
    idx_d = idx_q;
    if (step_go) begin
      if (cw.inc_idx) begin
        idx_d = 4'(idx_q + 4'd1);
      end
      case (cw.jump)
        JMP_DISPATCH: begin
          idx_d = 4'd0;
          if (in_accept) begin
            if (in_cfg_msg) begin
              upc_d = UpcConfigFwd;
            end else if (in_first_note) begin
              upc_d = UpcNoteStart;
            end else begin
              upc_d = UpcForward;
            end
          end
        end
        JMP_ALWAYS: upc_d = cw.target;
        JMP_EMPTY:  upc_d = empty ? cw.target : UpcSelHigh;
        JMP_LOOP: begin
          if (!last_member) begin
            upc_d = cw.target;
          end else if (is_cfg_q) begin
            upc_d = UpcDispatch;
          end else begin
            upc_d = UpcForward;
          end
        end
        JMP_NEXT:   upc_d = 3'(upc_q + 3'd1);
        default:    upc_d = UpcDispatch;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= UpcDispatch;
      idx_q       <= 4'd0;
      is_cfg_q    <= 1'b0;
      declared_q  <= 1'b0;
      zone_q      <= 1'b1;
      members_q   <= 4'd15;
      range_q     <= 7'd48;
      high_zero_q <= '0;
      low_six_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        is_cfg_q <= in_cfg_msg;
        if (in_cfg_msg || in_first_note) begin
          declared_q <= 1'b1;
        end
        if (in_ctrl && (in_i.data_one == CcSelectHigh)) begin
          high_zero_q[in_chi] <= (in_i.data_two == 7'd0);
        end
        if (in_ctrl && (in_i.data_one == CcSelectLow)) begin
          low_six_q[in_chi] <= (in_i.data_two == RpnLowMpe);
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_index_e'(cfg_i.index))
          CfgZoneIsLower: zone_q    <= cfg_i.data[0];
          CfgMemberCount: members_q <= cfg_i.data[3:0];
          CfgBendRange:   range_q   <= cfg_i.data;
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      st_q <= in_i.status_byte;
      d1_q <= in_i.data_one;
      d2_q <= in_i.data_two;
    end
    out_st_q   <= out_st_d;
    out_d1_q   <= out_d1_d;
    out_d2_q   <= out_d2_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_status   = out_st_q;
  assign out_o.out_data_one = out_d1_q;
  assign out_o.out_data_two = out_d2_q;
  assign out_o.last_of_run  = out_last_q;

endmodule
